// ----- sv/sacl_pkg.sv -----
// Shared constants, types and state codes of the set-associative LRU lookup.
`default_nettype none

package sacl_pkg;

   localparam int ADDR_W                = 7;
   localparam int WAYS_LOG2_W           = 2;
   localparam int LINE_USED_W           = 3;
   localparam int HIT_COUNT_W           = 16;
   localparam int STAMP_W               = 32;
   localparam int GROUP                 = 8;
   localparam int GROUP_W               = 3;
   localparam int LINES_DEFAULT         = 8;
   localparam int MEMORY_BLOCKS_DEFAULT = 32;

   localparam logic [WAYS_LOG2_W-1:0] WAYS_LOG2_RESET = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REDUCE2,
      ST_REDUCE3,
      ST_UPDATE
   } state_type;

   // one candidate line of a set during the oldest-stamp search
   typedef struct packed {
      logic               ok;
      logic [GROUP_W-1:0] lane;
      logic [STAMP_W-1:0] stamp;
   } pick_type;

endpackage

`default_nettype wire

// ----- sv/sacl_victim_pick.sv -----
// Registered three-level tree that finds the oldest live line of an eight-line row.
`default_nettype none

module sacl_victim_pick #(
   parameter int LANES = sacl_pkg::GROUP
) (
   input  wire logic                                       clock,
   input  wire logic [LANES-1:0][sacl_pkg::STAMP_W-1:0]    lane_stamp,
   input  wire logic [LANES-1:0]                           lane_live,
   output sacl_pkg::pick_type                              victim
);
   import sacl_pkg::*;

   pick_type leaf   [GROUP];
   pick_type lvl1_ff[GROUP/2];
   pick_type lvl2_ff[GROUP/4];
   pick_type lvl3_ff;

   // left side wins a tie, so the lowest line is kept
   function automatic pick_type older(input pick_type a, input pick_type b);
      pick_type r;
      if (a.ok && (!b.ok || a.stamp <= b.stamp)) r = a;
      else                                        r = b;
      return r;
   endfunction

   for (genvar l = 0; l < GROUP; l++) begin : g_leaf
      if (l < LANES) begin : g_used
         assign leaf[l] = '{ok: lane_live[l], lane: GROUP_W'(l), stamp: lane_stamp[l]};
      end else begin : g_pad
         assign leaf[l] = '{ok: 1'b0, lane: GROUP_W'(l), stamp: '0};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < GROUP/2; i++) lvl1_ff[i] <= older(leaf[2*i], leaf[2*i+1]);
      for (int i = 0; i < GROUP/4; i++) lvl2_ff[i] <= older(lvl1_ff[2*i], lvl1_ff[2*i+1]);
      lvl3_ff <= older(lvl2_ff[0], lvl2_ff[1]);
   end

   assign victim = lvl3_ff;

endmodule

`default_nettype wire

// ----- sv/set_assoc_cache_lru_lookup_core.sv -----
// Top level: set-associative cache lookup with LRU replacement over line memories.
//
// req_ channel: one word address per word (valid/stall). rsp_ channel: hit flag,
// line used and saturating hit count (valid/stall). csr_ channel: writes
// ways_log2 (1, 2, 4 or 8 ways); csr_ready is always high, write only when idle.
// For each word, the accept edge reads the set's row of tags and stamps from
// the line memories, ST_MATCH matches tags and starts the oldest-stamp search,
// ST_REDUCE2 and ST_REDUCE3 finish the registered search tree, and the
// write-back edge updates the row and loads the result register. The next
// word is taken the cycle after write-back, so one word is in flight at a time;
// the search tree and the one-row memory port set that.
// A stalled result holds in the output register; a following word is still
// taken and processed, and waits at write-back until the register frees.
// Reset (synchronous) empties the cache at once through per-row valid bits,
// clears the use and hit counters and sets two ways; no clearing pass.
`default_nettype none

module set_assoc_cache_lru_lookup_core #(
   parameter int LINES         = sacl_pkg::LINES_DEFAULT,
   parameter int MEMORY_BLOCKS = sacl_pkg::MEMORY_BLOCKS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [sacl_pkg::ADDR_W-1:0]         req_word_address,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_hit,
   output      logic [sacl_pkg::LINE_USED_W-1:0]    rsp_line_used,
   output      logic [sacl_pkg::HIT_COUNT_W-1:0]    rsp_hit_count,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [sacl_pkg::WAYS_LOG2_W-1:0]    csr_ways_log2
);
   import sacl_pkg::*;

   localparam int TAG_W   = $clog2(MEMORY_BLOCKS + 1);
   localparam int SPAN    = 2 * MEMORY_BLOCKS;
   localparam int LINE_W  = (LINES > GROUP) ? $clog2(LINES) : GROUP_W;
   localparam int EW      = LINE_W + 1;
   localparam int LANES   = (LINES < GROUP) ? LINES : GROUP;
   localparam int LANE_IW = $clog2(LANES);
   localparam int ROWS    = (LINES + GROUP - 1) / GROUP;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int NADDR   = 2 ** ADDR_W;

   // address -> block number and line base, worked out at elaboration
   logic [TAG_W-1:0]  blk_tab  [NADDR];
   logic [LINE_W-1:0] base_tab [NADDR];

   for (genvar a = 0; a < NADDR; a++) begin : g_addr
      localparam int AWRAP = ((a + SPAN - 1) % SPAN) + 1;
      localparam int BLK   = (AWRAP + 1) / 2;
      assign blk_tab[a]  = TAG_W'(BLK);
      assign base_tab[a] = LINE_W'((BLK - 1) % LINES);
   end

   // line memories, one row of up to eight lines per entry
   logic [LANES-1:0][TAG_W-1:0]   tag_mem   [ROWS];
   logic [LANES-1:0][STAMP_W-1:0] stamp_mem [ROWS];
   logic [ROWS-1:0]               row_valid_ff;

   state_type                     state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [WAYS_LOG2_W-1:0]        ways_log2_ff;
   logic [STAMP_W-1:0]            use_counter_ff, use_counter_in;
   logic [HIT_COUNT_W-1:0]        hits_ff, hits_in;

   logic [LANES-1:0][TAG_W-1:0]   rd_tag_ff;
   logic [LANES-1:0][STAMP_W-1:0] rd_stamp_ff;
   logic [TAG_W-1:0]              blk_ff;
   logic [LINE_W-1:0]             start_ff;
   logic [EW-1:0]                 end_ff;
   logic [ROW_W-1:0]              row_ff;
   logic                          hit_ff;
   logic [GROUP_W-1:0]            hit_lane_ff;
   logic                          rsp_hit_ff;
   logic [LINE_USED_W-1:0]        rsp_line_ff;
   logic [HIT_COUNT_W-1:0]        rsp_hit_count_ff;

   logic                          accept, commit, out_busy;
   logic [LINE_W-1:0]             base, start_in;
   logic [EW-1:0]                 end_in, sum_end;
   logic [GROUP_W:0]              ways_pow;
   logic                          full_set;
   logic [LANES-1:0]              lane_live;
   logic                          hit_in;
   logic [GROUP_W-1:0]            hit_lane_in;
   logic [GROUP_W-1:0]            use_lane;
   logic [LANES-1:0][TAG_W-1:0]   wr_tag;
   logic [LANES-1:0][STAMP_W-1:0] wr_stamp;
   pick_type                      victim;

   // ---- set bounds of the arriving word ----
   always_comb begin
      base     = base_tab[req_word_address];
      ways_pow = (GROUP_W + 1)'(1) << ways_log2_ff;
      full_set = 32'(ways_pow) >= LINES;
      sum_end  = EW'(base & ({LINE_W{1'b1}} << ways_log2_ff)) + EW'(ways_pow);
      if (full_set) begin
         start_in = '0;
         end_in   = EW'(LINES);
      end else begin
         start_in = base & ({LINE_W{1'b1}} << ways_log2_ff);
         end_in   = (sum_end > EW'(LINES)) ? EW'(LINES) : sum_end;
      end
   end

   // ---- lanes of the read row that belong to the set, and tag match ----
   always_comb begin
      hit_in      = 1'b0;
      hit_lane_in = '0;
      for (int l = 0; l < LANES; l++) begin
         lane_live[l] = ((EW'(row_ff) << GROUP_W) + EW'(l) >= EW'(start_ff)) &&
                        ((EW'(row_ff) << GROUP_W) + EW'(l) <  end_ff);
      end
      for (int l = LANES - 1; l >= 0; l--) begin
         if (lane_live[l] && rd_tag_ff[l] == blk_ff) begin
            hit_in      = 1'b1;
            hit_lane_in = GROUP_W'(l);
         end
      end
   end

   sacl_victim_pick #(
      .LANES (LANES)
   ) u_pick (
      .clock      (clock),
      .lane_stamp (rd_stamp_ff),
      .lane_live  (lane_live),
      .victim     (victim)
   );

   // ---- write-back values ----
   always_comb begin
      use_counter_in = (&use_counter_ff) ? use_counter_ff : use_counter_ff + 1'b1;
      hits_in        = (hit_ff && !(&hits_ff)) ? hits_ff + 1'b1 : hits_ff;
      use_lane       = hit_ff ? hit_lane_ff : victim.lane;
      wr_tag         = rd_tag_ff;
      wr_stamp       = rd_stamp_ff;
      wr_tag[use_lane[LANE_IW-1:0]]   = blk_ff;
      wr_stamp[use_lane[LANE_IW-1:0]] = use_counter_in;
   end

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MATCH;
         ST_MATCH:   state_in = ST_REDUCE2;
         ST_REDUCE2: state_in = ST_REDUCE3;
         ST_REDUCE3: state_in = ST_UPDATE;
         ST_UPDATE:  if (!out_busy) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_busy     = rsp_valid_ff && rsp_stall;
      req_stall    = (state_ff != ST_IDLE);
      accept       = (state_ff == ST_IDLE) && req_valid;
      commit       = (state_ff == ST_UPDATE) && !out_busy;
      rsp_valid_in = commit || out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         ways_log2_ff   <= WAYS_LOG2_RESET;
         use_counter_ff <= '0;
         hits_ff        <= '0;
         row_valid_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) ways_log2_ff <= csr_ways_log2;
         if (commit) begin
            use_counter_ff       <= use_counter_in;
            hits_ff              <= hits_in;
            row_valid_ff[row_ff] <= 1'b1;
         end
      end
   end

   // memory read at accept, row write-back at commit
   always_ff @(posedge clock) begin
      if (accept) begin
         blk_ff   <= blk_tab[req_word_address];
         start_ff <= start_in;
         end_ff   <= end_in;
         row_ff   <= ROW_W'(start_in >> GROUP_W);
         if (row_valid_ff[ROW_W'(start_in >> GROUP_W)]) begin
            rd_tag_ff   <= tag_mem[ROW_W'(start_in >> GROUP_W)];
            rd_stamp_ff <= stamp_mem[ROW_W'(start_in >> GROUP_W)];
         end else begin
            rd_tag_ff   <= '0;
            rd_stamp_ff <= '0;
         end
      end
      if (state_ff == ST_MATCH) begin
         hit_ff      <= hit_in;
         hit_lane_ff <= hit_lane_in;
      end
      if (commit) begin
         tag_mem[row_ff]   <= wr_tag;
         stamp_mem[row_ff] <= wr_stamp;
         rsp_hit_ff        <= hit_ff;
         rsp_line_ff       <= LINE_USED_W'(use_lane);
         rsp_hit_count_ff  <= hits_in;
      end
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_line_used = rsp_line_ff;
   assign rsp_hit_count = rsp_hit_count_ff;

`ifndef SYNTH
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid)
      else $error("write-back did not load a result");

   a_victim_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (hit_ff || victim.ok))
      else $error("no live line found for replacement");

   a_stamp_moves: assert property (@(posedge clock) disable iff (reset)
      commit |=> (use_counter_ff != $past(use_counter_ff)) || (&$past(use_counter_ff)))
      else $error("use counter did not advance on an access");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the set-associative LRU cache lookup core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sacl_pkg::*;

   localparam int NUM_LINES   = LINES_DEFAULT;
   localparam int ADDR_SPAN   = 2 * MEMORY_BLOCKS_DEFAULT;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 180;

   typedef struct packed {
      logic                   hit;
      logic [LINE_USED_W-1:0] line_used;
      logic [HIT_COUNT_W-1:0] hit_count;
   } lookup_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [ADDR_W-1:0]      req_word_address = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic                   rsp_hit;
   logic [LINE_USED_W-1:0] rsp_line_used;
   logic [HIT_COUNT_W-1:0] rsp_hit_count;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [WAYS_LOG2_W-1:0] csr_ways_log2    = '0;

   always #2 clock = ~clock;

   set_assoc_cache_lru_lookup_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word_address (req_word_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_line_used    (rsp_line_used),
      .rsp_hit_count    (rsp_hit_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_ways_log2    (csr_ways_log2)
   );

   // Cache shadow: tags, LRU stamps and counters, plus the lookups still owed.
   class lru_scoreboard_type;
      logic [5:0]             tag_q   [NUM_LINES];
      logic [STAMP_W-1:0]     stamp_q [NUM_LINES];
      logic [STAMP_W-1:0]     use_ctr;
      logic [HIT_COUNT_W-1:0] hits;
      logic [WAYS_LOG2_W-1:0] ways_log2;
      lookup_type             lookups_due [$];
      int                     errors;
      int                     words;
      int                     hit_words;

      function new();
         foreach (tag_q[i]) begin
            tag_q[i]   = '0;
            stamp_q[i] = '0;
         end
         use_ctr   = '0;
         hits      = '0;
         ways_log2 = WAYS_LOG2_RESET;
         errors    = 0;
         words     = 0;
         hit_words = 0;
      endfunction

      function void set_ways(logic [WAYS_LOG2_W-1:0] v);
         ways_log2 = v;
      endfunction

      function void note_word(logic [ADDR_W-1:0] addr);
         int unsigned a, blk, ways, lo, hi, victim, j;
         bit          found;
         lookup_type  r;
         a = addr;
         // out-of-range addresses fold back, so 0 is the last word
         a = ((a + ADDR_SPAN - 1) % ADDR_SPAN) + 1;
         blk = (a + 1) / 2;
         ways = 1 << ways_log2;
         if (ways > NUM_LINES) ways = NUM_LINES;
         lo = (((blk - 1) % NUM_LINES) / ways) * ways;
         hi = lo + ways;
         if (hi > NUM_LINES) hi = NUM_LINES;
         victim = lo;
         found  = 1'b0;
         for (j = lo; j < hi; j++) begin
            if (!found && tag_q[j] == blk) begin
               victim = j;
               found  = 1'b1;
            end
         end
         if (use_ctr != '1) use_ctr++;
         if (found) begin
            if (hits != '1) hits++;
            hit_words++;
         end else begin
            // oldest stamp loses; lowest line wins a tie
            victim = lo;
            for (j = lo + 1; j < hi; j++) begin
               if (stamp_q[j] < stamp_q[victim]) victim = j;
            end
            tag_q[victim] = blk[5:0];
         end
         stamp_q[victim] = use_ctr;
         r.hit       = found;
         r.line_used = victim[LINE_USED_W-1:0];
         r.hit_count = hits;
         lookups_due.push_back(r);
         words++;
      endfunction

      function void check_result(lookup_type got);
         lookup_type want;
         if (lookups_due.size() == 0) begin
            $error("result word with no lookup pending");
            errors++;
            return;
         end
         want = lookups_due.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            errors++;
         end
         if (got.line_used !== want.line_used) begin
            $error("line_used: expected %0d, actual %0d", want.line_used, got.line_used);
            errors++;
         end
         if (got.hit_count !== want.hit_count) begin
            $error("hit_count: expected %0d, actual %0d", want.hit_count, got.hit_count);
            errors++;
         end
      endfunction
   endclass

   lru_scoreboard_type sb = new();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_word(req_word_address);
         if (rsp_valid && !rsp_stall) sb.check_result({rsp_hit, rsp_line_used, rsp_hit_count});
         if (csr_valid && csr_ready) sb.set_ways(csr_ways_log2);
      end
   end

   // Receiver: stall density changes per segment, plus one long hold mid-run.
   int stall_pct = 0;
   int seg_left  = 0;
   int hold_left = 0;
   int rsp_taken = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_taken >= 400 && req_valid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(8, 64);
               case ($urandom_range(4))
                  0, 1:    stall_pct = 0;
                  2:       stall_pct = 25;
                  3:       stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end else begin
               seg_left--;
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // leaves valid high; the caller lowers it or offers the next word
   task automatic send_word(input logic [ADDR_W-1:0] addr);
      req_valid        <= 1'b1;
      req_word_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (sb.lookups_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_ways(input logic [WAYS_LOG2_W-1:0] v);
      req_valid <= 1'b0;
      wait_idle();
      csr_valid     <= 1'b1;
      csr_ways_log2 <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_list(input logic [ADDR_W-1:0] q [$]);
      foreach (q[i]) send_word(q[i]);
   endtask

   // mostly a sliding working set so hits and evictions both happen
   function automatic logic [ADDR_W-1:0] pick_address(int base, int span_words);
      if ($urandom_range(99) < 75)
         return ADDR_W'((base + $urandom_range(0, span_words - 1)) % ADDR_SPAN + 1);
      return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
   endfunction

   task automatic run_phase(input int n_words);
      int sent, burst, span_words, base;
      sent       = 0;
      span_words = $urandom_range(4, 24);
      base       = $urandom_range(0, ADDR_SPAN - 1);
      while (sent < n_words) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < n_words; k++) begin
            send_word(pick_address(base, span_words));
            sent++;
         end
         if ($urandom_range(9) == 0) base = $urandom_range(0, ADDR_SPAN - 1);
         if ($urandom_range(3) != 0) pause_sender($urandom_range(1, 6));
      end
   endtask

   initial begin
      logic [ADDR_W-1:0]      dq [$];
      logic [WAYS_LOG2_W-1:0] phase_ways [8];
      phase_ways = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting, two ways: tie on empty lines, same-block hit, wrap of 0 and 127
      dq = '{7'd1, 7'd2, 7'd0, 7'd64, 7'd127, 7'd65, 7'd17, 7'd33, 7'd1, 7'd100};
      send_list(dq);
      // direct mapped: conflicting blocks
      write_ways(2'd0);
      dq = '{7'd1, 7'd17, 7'd17, 7'd1, 7'd63};
      send_list(dq);
      // fully associative: fill all lines, then evict the oldest
      write_ways(2'd3);
      dq = '{7'd1, 7'd3, 7'd5, 7'd7, 7'd9, 7'd11, 7'd13, 7'd15, 7'd17, 7'd2};
      send_list(dq);

      foreach (phase_ways[p]) begin
         write_ways(phase_ways[p]);
         run_phase(PHASE_WORDS);
      end

      req_valid <= 1'b0;
      wait_idle();
      $display("covered %0d lookups, %0d of them hits, at 1, 2, 4 and 8 ways", sb.words,
               sb.hit_words);
      $display("with random gaps, result stalls and one long result hold");
      if (sb.errors == 0 && sb.lookups_due.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
